// ===== sv/masked_byte_pattern_search_assert.svh =====
// Assertion macros for the masked byte pattern search block.
// The including module must provide i_clk and the active-low reset i_rst_n.
`ifndef MASKED_BYTE_PATTERN_SEARCH_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SEARCH_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MBPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MBPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mbps_pkg.sv =====
// Shared types and constants for the masked byte pattern search block.
// No dependencies; used by the register block and the top level.
package mbps_pkg;

    localparam int unsigned MAX_PATTERN_LEN_DEF = 32;
    localparam int unsigned PAT_BYTES           = 32;
    localparam int unsigned LEN_W               = 6;
    localparam int unsigned ADDR_W              = 32;
    localparam int unsigned APB_ADDR_W          = 6;
    localparam int unsigned APB_DATA_W          = 64;

    typedef enum logic [2:0] {
        REG_PAT_0_7   = 3'd0,
        REG_PAT_8_15  = 3'd1,
        REG_PAT_16_23 = 3'd2,
        REG_PAT_24_31 = 3'd3,
        REG_WILDCARD  = 3'd4,
        REG_LENGTH    = 3'd5,
        REG_BASE      = 3'd6
    } t_reg_idx;

    // Scalar view of the configuration, prepared ahead of the compare stage.
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic              len_nz;
        logic [ADDR_W-1:0] base_minus_len;
    } t_cfg_view;

endpackage

// ===== sv/mbps_if.sv =====
// Valid/ready stream interfaces for the byte input and the result output.
// No dependencies.
interface mbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_region;

    modport source (output valid, output data_byte, output end_of_region, input ready);
    modport sink   (input valid, input data_byte, input end_of_region, output ready);
endinterface

interface mbps_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_address;

    modport source (output valid, output found, output match_address, input ready);
    modport sink   (input valid, input found, input match_address, output ready);
endinterface

// ===== sv/mbps_cfg.sv =====
// APB register block for the masked byte pattern search block.
// Depends on mbps_pkg; also registers the length-aligned pattern for the compare.
module mbps_cfg #(
    parameter int unsigned MAX_PATTERN_LEN = mbps_pkg::MAX_PATTERN_LEN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mbps_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mbps_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mbps_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output mbps_pkg::t_cfg_view              o_view,
    output logic [7:0]                       o_apat [MAX_PATTERN_LEN],
    output logic [MAX_PATTERN_LEN-1:0]       o_care
);
    import mbps_pkg::*;

    logic [APB_DATA_W-1:0] r_pat [4];
    logic [31:0]           r_mask;
    logic [LEN_W-1:0]      r_len;
    logic [ADDR_W-1:0]     r_base;

    t_reg_idx              w_idx;
    logic                  w_wr;
    logic [7:0]            w_pat_byte [PAT_BYTES];
    logic [LEN_W-1:0]      w_len_eff;
    logic [7:0]            n_apat [MAX_PATTERN_LEN];
    logic [MAX_PATTERN_LEN-1:0] n_care;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[5:3]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat[0] <= '0;
            r_pat[1] <= '0;
            r_pat[2] <= '0;
            r_pat[3] <= '0;
            r_mask   <= '0;
            r_len    <= LEN_W'(1);
            r_base   <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_PAT_0_7:   r_pat[0] <= pwdata;
                REG_PAT_8_15:  r_pat[1] <= pwdata;
                REG_PAT_16_23: r_pat[2] <= pwdata;
                REG_PAT_24_31: r_pat[3] <= pwdata;
                REG_WILDCARD:  r_mask   <= pwdata[31:0];
                REG_LENGTH:    r_len    <= pwdata[LEN_W-1:0];
                REG_BASE:      r_base   <= pwdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_PAT_0_7:   prdata = r_pat[0];
            REG_PAT_8_15:  prdata = r_pat[1];
            REG_PAT_16_23: prdata = r_pat[2];
            REG_PAT_24_31: prdata = r_pat[3];
            REG_WILDCARD:  prdata = {32'd0, r_mask};
            REG_LENGTH:    prdata = {{(APB_DATA_W-LEN_W){1'b0}}, r_len};
            REG_BASE:      prdata = {32'd0, r_base};
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        for (int k = 0; k < PAT_BYTES; k++) begin
            w_pat_byte[k] = r_pat[k / 8][(k % 8) * 8 +: 8];
        end
    end

    // Lengths above the window depth saturate to the window depth.
    assign w_len_eff = (r_len > LEN_W'(MAX_PATTERN_LEN)) ? LEN_W'(MAX_PATTERN_LEN) : r_len;

    // Window entry j holds the byte that pattern position len-1-j must match,
    // so the compare stage needs no variable indexing.
    always_comb begin
        logic [LEN_W-1:0] pos;
        for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
            pos = w_len_eff - LEN_W'(j) - LEN_W'(1);
            if (LEN_W'(j) < w_len_eff) begin
                n_apat[j] = w_pat_byte[pos[4:0]];
                n_care[j] = !r_mask[pos[4:0]];
            end else begin
                n_apat[j] = '0;
                n_care[j] = 1'b0;
            end
        end
    end

    // Derived values are registered from the registers; the user must make configuration
    // changes only while the block is idle, and the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        o_apat                <= n_apat;
        o_care                <= n_care;
        o_view.len            <= w_len_eff;
        o_view.len_nz         <= (w_len_eff != '0);
        o_view.base_minus_len <= r_base - {{(ADDR_W-LEN_W){1'b0}}, w_len_eff};
    end

endmodule

// ===== sv/masked_byte_pattern_search.sv =====
// Masked byte pattern search: a byte transaction is registered at the input and its
// result is then registered in the output register, where it waits until it is taken.
// One byte is accepted every cycle while results are taken; the window register and
// the parallel compare stage set that rate. Reset is synchronous, active low: the
// configuration, counters and flags clear and the pattern length returns to one.
// Depends on mbps_pkg, mbps_if and mbps_cfg.
`include "masked_byte_pattern_search_assert.svh"

module masked_byte_pattern_search #(
    parameter int unsigned MAX_PATTERN_LEN = mbps_pkg::MAX_PATTERN_LEN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mbps_in_if.sink                          i_in,
    mbps_out_if.source                       o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mbps_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mbps_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mbps_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import mbps_pkg::*;

    t_cfg_view                  w_view;
    logic [7:0]                 w_apat [MAX_PATTERN_LEN];
    logic [MAX_PATTERN_LEN-1:0] w_care;

    logic [7:0]        r_window [MAX_PATTERN_LEN];
    logic [ADDR_W-1:0] r_count;
    logic              r_s1_valid;
    logic [ADDR_W-1:0] r_s1_seen;
    logic              r_s1_counted;
    logic              r_s1_last;
    logic              r_matched;
    logic              r_out_valid;
    logic              r_found;
    logic [ADDR_W-1:0] r_addr;

    logic              w_in_acc;
    logic              w_adv;
    logic              w_counted;
    logic [ADDR_W-1:0] n_seen;
    logic [MAX_PATTERN_LEN-1:0] w_eq;
    logic              w_hit;
    logic              w_emit;

    mbps_cfg #(
        .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_view  (w_view),
        .o_apat  (w_apat),
        .o_care  (w_care)
    );

    // Stage two moves on when the result register is free or being emptied.
    assign w_adv       = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || w_adv;
    assign w_in_acc    = i_in.valid && i_in.ready;

    assign w_counted = (r_count != '1);
    assign n_seen    = w_counted ? r_count + ADDR_W'(1) : r_count;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_window[0] <= i_in.data_byte;
            for (int j = 1; j < MAX_PATTERN_LEN; j++) begin
                r_window[j] <= r_window[j-1];
            end
            r_s1_seen    <= n_seen;
            r_s1_counted <= w_counted;
            r_s1_last    <= i_in.end_of_region;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_count <= i_in.end_of_region ? '0 : n_seen;
            end
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
            w_eq[j] = !w_care[j] || (r_window[j] == w_apat[j]);
        end
    end

    assign w_hit  = !r_matched && r_s1_counted && w_view.len_nz &&
                    (r_s1_seen >= {{(ADDR_W-LEN_W){1'b0}}, w_view.len}) && (&w_eq);
    assign w_emit = w_hit || (r_s1_last && !r_matched);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matched   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                if (r_s1_last) begin
                    r_matched <= 1'b0;
                end else if (w_hit) begin
                    r_matched <= 1'b1;
                end
            end
            if (w_adv) begin
                r_out_valid <= w_emit;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_found <= w_hit;
            r_addr  <= w_hit ? w_view.base_minus_len + r_s1_seen : '0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.found         = r_found;
    assign o_out.match_address = r_addr;

    `MBPS_ASSERT_NOW(a_notfound_zero, r_out_valid && !r_found, r_addr == '0, "not-found result carries a non-zero address")
    `MBPS_ASSERT_NEXT(a_region_clears_flag, w_adv && r_s1_last, !r_matched, "match flag survived the end of a region")
    `MBPS_ASSERT_NEXT(a_hit_sets_flag, w_adv && w_hit && !r_s1_last, r_matched && r_out_valid && r_found, "match did not produce a found result")
    `MBPS_ASSERT_NEXT(a_last_clears_count, w_in_acc && i_in.end_of_region, r_count == '0, "byte count not cleared after the last byte of a region")

endmodule
